// File: design/packed_hermitian_block_matvec_unit_assert.svh
// Assertion macros shared by the block. Each macro expects clk and rst_n in scope.
`ifndef PACKED_HERMITIAN_BLOCK_MATVEC_UNIT_ASSERT_SVH
`define PACKED_HERMITIAN_BLOCK_MATVEC_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PHBM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PHBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/phbm_pkg.sv
package phbm_pkg;

    localparam int BLOCK_DIM   = 6;
    localparam int FRAC_BITS   = 24;
    localparam int LOWER_COUNT = BLOCK_DIM * (BLOCK_DIM - 1) / 2;

    localparam int KIND_W = 2;
    localparam int IDX_W  = 4;
    localparam int DATA_W = 32;
    localparam int ROW_W  = 3;
    localparam int ACC_W  = 64;

    // Row index, loop index that can also hold BLOCK_DIM, and packed lower address.
    localparam int J_W  = (BLOCK_DIM > 1) ? $clog2(BLOCK_DIM) : 1;
    localparam int K_W  = $clog2(BLOCK_DIM + 1);
    localparam int L_AW = (LOWER_COUNT > 1) ? $clog2(LOWER_COUNT) : 1;

    localparam int PC_W = 4;

    localparam logic [KIND_W-1:0] KIND_DIAG = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OFF  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VEC  = 2'd2;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_XRE_D,
        MUL_XIM_D,
        MUL_M0X0,
        MUL_M1X1,
        MUL_M0X1,
        MUL_M1X0
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_LOAD_RE,
        ACC_LOAD_IM,
        ACC_ADD_RE,
        ACC_ADD_IM,
        ACC_LOWER_SUB_RE,
        ACC_UPPER_SUB_IM
    } acc_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLEAR,
        CNT_INC
    } cnt_op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_START,
        COND_K_DONE,
        COND_K_EQ_J,
        COND_OUT_BUSY,
        COND_MORE_ROWS
    } cond_t;

    // Program step addresses.
    localparam logic [PC_W-1:0] STEP_IDLE       = 4'd0;
    localparam logic [PC_W-1:0] STEP_RD_DIAG    = 4'd1;
    localparam logic [PC_W-1:0] STEP_MUL_DRE    = 4'd2;
    localparam logic [PC_W-1:0] STEP_MUL_DIM    = 4'd3;
    localparam logic [PC_W-1:0] STEP_ACC_DIM    = 4'd4;
    localparam logic [PC_W-1:0] STEP_KTEST_END  = 4'd5;
    localparam logic [PC_W-1:0] STEP_KTEST_DIAG = 4'd6;
    localparam logic [PC_W-1:0] STEP_RD_OFF     = 4'd7;
    localparam logic [PC_W-1:0] STEP_M0X0       = 4'd8;
    localparam logic [PC_W-1:0] STEP_M1X1       = 4'd9;
    localparam logic [PC_W-1:0] STEP_M0X1       = 4'd10;
    localparam logic [PC_W-1:0] STEP_M1X0       = 4'd11;
    localparam logic [PC_W-1:0] STEP_ACC_LAST   = 4'd12;
    localparam logic [PC_W-1:0] STEP_KINC       = 4'd13;
    localparam logic [PC_W-1:0] STEP_OUT        = 4'd14;
    localparam logic [PC_W-1:0] STEP_ROW_NEXT   = 4'd15;

    typedef struct packed {
        logic            rd_diag;
        logic            rd_off;
        mul_sel_t        mul_sel;
        acc_op_t         acc_op;
        cnt_op_t         k_op;
        cnt_op_t         j_op;
        logic            emit;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    localparam ucode_t UC_NOP = '{
        rd_diag: 1'b0,
        rd_off:  1'b0,
        mul_sel: MUL_NONE,
        acc_op:  ACC_NONE,
        k_op:    CNT_HOLD,
        j_op:    CNT_HOLD,
        emit:    1'b0,
        cond:    COND_NEXT,
        target:  STEP_IDLE
    };

    // Datapath controls issued by the sequencer.
    typedef struct packed {
        logic            rd_diag;
        logic            rd_off;
        mul_sel_t        mul_sel;
        acc_op_t         acc_op;
        logic            upper;
        logic [J_W-1:0]  diag_addr;
        logic [J_W-1:0]  vec_addr;
        logic [L_AW-1:0] lower_addr;
    } ctrl_t;

    // Store writes from the input channel.
    typedef struct packed {
        logic              diag_we;
        logic              lower_we;
        logic              vec_we;
        logic [J_W-1:0]    short_addr;
        logic [L_AW-1:0]   lower_addr;
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
    } load_t;

    // Start position of row n in the packed lower triangle: n*(n-1)/2.
    function automatic logic [L_AW-1:0] tri_base(input logic [K_W-1:0] n);
        logic [2*K_W-1:0] p;
        p = n * (n - K_W'(1));
        return L_AW'(p >> 1);
    endfunction

endpackage

// File: design/phbm_ucode_rom.sv
module phbm_ucode_rom (
    input  logic [phbm_pkg::PC_W-1:0] pc,
    output phbm_pkg::ucode_t          uc
);

    always_comb
    begin
        uc = phbm_pkg::UC_NOP;
        unique case (pc)
            phbm_pkg::STEP_IDLE:
            begin
                uc.j_op   = phbm_pkg::CNT_CLEAR;
                uc.cond   = phbm_pkg::COND_NO_START;
                uc.target = phbm_pkg::STEP_IDLE;
            end
            phbm_pkg::STEP_RD_DIAG:
            begin
                uc.rd_diag = 1'b1;
                uc.k_op    = phbm_pkg::CNT_CLEAR;
            end
            phbm_pkg::STEP_MUL_DRE:
            begin
                uc.mul_sel = phbm_pkg::MUL_XRE_D;
            end
            phbm_pkg::STEP_MUL_DIM:
            begin
                uc.mul_sel = phbm_pkg::MUL_XIM_D;
                uc.acc_op  = phbm_pkg::ACC_LOAD_RE;
            end
            phbm_pkg::STEP_ACC_DIM:
            begin
                uc.acc_op = phbm_pkg::ACC_LOAD_IM;
            end
            phbm_pkg::STEP_KTEST_END:
            begin
                uc.cond   = phbm_pkg::COND_K_DONE;
                uc.target = phbm_pkg::STEP_OUT;
            end
            phbm_pkg::STEP_KTEST_DIAG:
            begin
                uc.cond   = phbm_pkg::COND_K_EQ_J;
                uc.target = phbm_pkg::STEP_KINC;
            end
            phbm_pkg::STEP_RD_OFF:
            begin
                uc.rd_off = 1'b1;
            end
            phbm_pkg::STEP_M0X0:
            begin
                uc.mul_sel = phbm_pkg::MUL_M0X0;
            end
            phbm_pkg::STEP_M1X1:
            begin
                uc.mul_sel = phbm_pkg::MUL_M1X1;
                uc.acc_op  = phbm_pkg::ACC_ADD_RE;
            end
            phbm_pkg::STEP_M0X1:
            begin
                uc.mul_sel = phbm_pkg::MUL_M0X1;
                uc.acc_op  = phbm_pkg::ACC_LOWER_SUB_RE;
            end
            phbm_pkg::STEP_M1X0:
            begin
                uc.mul_sel = phbm_pkg::MUL_M1X0;
                uc.acc_op  = phbm_pkg::ACC_ADD_IM;
            end
            phbm_pkg::STEP_ACC_LAST:
            begin
                uc.acc_op = phbm_pkg::ACC_UPPER_SUB_IM;
                uc.k_op   = phbm_pkg::CNT_INC;
                uc.cond   = phbm_pkg::COND_ALWAYS;
                uc.target = phbm_pkg::STEP_KTEST_END;
            end
            phbm_pkg::STEP_KINC:
            begin
                uc.k_op   = phbm_pkg::CNT_INC;
                uc.cond   = phbm_pkg::COND_ALWAYS;
                uc.target = phbm_pkg::STEP_KTEST_END;
            end
            phbm_pkg::STEP_OUT:
            begin
                uc.emit   = 1'b1;
                uc.cond   = phbm_pkg::COND_OUT_BUSY;
                uc.target = phbm_pkg::STEP_OUT;
            end
            phbm_pkg::STEP_ROW_NEXT:
            begin
                // Falling through wraps the step counter back to idle.
                uc.j_op   = phbm_pkg::CNT_INC;
                uc.cond   = phbm_pkg::COND_MORE_ROWS;
                uc.target = phbm_pkg::STEP_RD_DIAG;
            end
            default:
            begin
                uc = phbm_pkg::UC_NOP;
            end
        endcase
    end

endmodule

// File: design/phbm_sequencer.sv
module phbm_sequencer (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     out_busy,
    output phbm_pkg::ctrl_t          ctrl,
    output logic                     emit,
    output logic                     idle,
    output logic [phbm_pkg::J_W-1:0] row_idx,
    output logic                     last_row
);

    logic [phbm_pkg::PC_W-1:0] pc_reg;
    logic [phbm_pkg::PC_W-1:0] pc_next;
    logic [phbm_pkg::J_W-1:0]  j_reg;
    logic [phbm_pkg::J_W-1:0]  j_next;
    logic [phbm_pkg::K_W-1:0]  k_reg;
    logic [phbm_pkg::K_W-1:0]  k_next;
    phbm_pkg::ucode_t          uc;
    logic                      taken;
    logic                      upper;

    phbm_ucode_rom u_rom (
        .pc (pc_reg),
        .uc (uc)
    );

    assign upper = k_reg > phbm_pkg::K_W'(j_reg);

    always_comb
    begin
        unique case (uc.cond)
            phbm_pkg::COND_NEXT:      taken = 1'b0;
            phbm_pkg::COND_ALWAYS:    taken = 1'b1;
            phbm_pkg::COND_NO_START:  taken = !start;
            phbm_pkg::COND_K_DONE:    taken = k_reg == phbm_pkg::K_W'(phbm_pkg::BLOCK_DIM);
            phbm_pkg::COND_K_EQ_J:    taken = k_reg == phbm_pkg::K_W'(j_reg);
            phbm_pkg::COND_OUT_BUSY:  taken = out_busy;
            phbm_pkg::COND_MORE_ROWS:
                taken = j_reg != phbm_pkg::J_W'(phbm_pkg::BLOCK_DIM - 1);
            default:                  taken = 1'b0;
        endcase
        pc_next = taken ? uc.target : pc_reg + phbm_pkg::PC_W'(1);

        unique case (uc.k_op)
            phbm_pkg::CNT_CLEAR: k_next = '0;
            phbm_pkg::CNT_INC:   k_next = k_reg + phbm_pkg::K_W'(1);
            default:             k_next = k_reg;
        endcase
        unique case (uc.j_op)
            phbm_pkg::CNT_CLEAR: j_next = '0;
            phbm_pkg::CNT_INC:   j_next = j_reg + phbm_pkg::J_W'(1);
            default:             j_next = j_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= phbm_pkg::STEP_IDLE;
            j_reg  <= '0;
            k_reg  <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
            j_reg  <= j_next;
            k_reg  <= k_next;
        end
    end

    always_comb
    begin
        ctrl.rd_diag   = uc.rd_diag;
        ctrl.rd_off    = uc.rd_off;
        ctrl.mul_sel   = uc.mul_sel;
        ctrl.acc_op    = uc.acc_op;
        ctrl.upper     = upper;
        ctrl.diag_addr = j_reg;
        ctrl.vec_addr  = uc.rd_diag ? j_reg : phbm_pkg::J_W'(k_reg);
        ctrl.lower_addr = upper
            ? phbm_pkg::tri_base(k_reg) + phbm_pkg::L_AW'(j_reg)
            : phbm_pkg::tri_base(phbm_pkg::K_W'(j_reg)) + phbm_pkg::L_AW'(k_reg);
    end

    assign emit     = uc.emit && !out_busy;
    assign idle     = pc_reg == phbm_pkg::STEP_IDLE;
    assign row_idx  = j_reg;
    assign last_row = j_reg == phbm_pkg::J_W'(phbm_pkg::BLOCK_DIM - 1);

endmodule

// File: design/phbm_datapath.sv
module phbm_datapath (
    input  logic                               clk,
    input  phbm_pkg::load_t                    load,
    input  phbm_pkg::ctrl_t                    ctrl,
    output logic signed [phbm_pkg::DATA_W-1:0] res_re,
    output logic signed [phbm_pkg::DATA_W-1:0] res_im
);

    localparam logic signed [phbm_pkg::ACC_W-1:0] MAX64 = {1'b0, {(phbm_pkg::ACC_W-1){1'b1}}};
    localparam logic signed [phbm_pkg::ACC_W-1:0] MIN64 = {1'b1, {(phbm_pkg::ACC_W-1){1'b0}}};
    localparam logic signed [phbm_pkg::ACC_W-1:0] MAX32 =
        {{(phbm_pkg::ACC_W-phbm_pkg::DATA_W+1){1'b0}}, {(phbm_pkg::DATA_W-1){1'b1}}};
    localparam logic signed [phbm_pkg::ACC_W-1:0] MIN32 =
        {{(phbm_pkg::ACC_W-phbm_pkg::DATA_W+1){1'b1}}, {(phbm_pkg::DATA_W-1){1'b0}}};

    logic [phbm_pkg::DATA_W-1:0]   diag_mem  [phbm_pkg::BLOCK_DIM];
    logic [2*phbm_pkg::DATA_W-1:0] lower_mem [phbm_pkg::LOWER_COUNT];
    logic [2*phbm_pkg::DATA_W-1:0] vec_mem   [phbm_pkg::BLOCK_DIM];

    logic signed [phbm_pkg::DATA_W-1:0] d_rd_reg;
    logic signed [phbm_pkg::DATA_W-1:0] m0_rd_reg;
    logic signed [phbm_pkg::DATA_W-1:0] m1_rd_reg;
    logic signed [phbm_pkg::DATA_W-1:0] x0_rd_reg;
    logic signed [phbm_pkg::DATA_W-1:0] x1_rd_reg;
    logic signed [phbm_pkg::DATA_W-1:0] op_a;
    logic signed [phbm_pkg::DATA_W-1:0] op_b;
    logic signed [phbm_pkg::ACC_W-1:0]  product_reg;
    logic signed [phbm_pkg::ACC_W-1:0]  product_next;
    logic signed [phbm_pkg::ACC_W-1:0]  acc_re_reg;
    logic signed [phbm_pkg::ACC_W-1:0]  acc_re_next;
    logic signed [phbm_pkg::ACC_W-1:0]  acc_im_reg;
    logic signed [phbm_pkg::ACC_W-1:0]  acc_im_next;

    function automatic logic signed [phbm_pkg::ACC_W-1:0] sat_add(
        input logic signed [phbm_pkg::ACC_W-1:0] a,
        input logic signed [phbm_pkg::ACC_W-1:0] b,
        input logic                              sub
    );
        logic signed [phbm_pkg::ACC_W:0] s;
        logic signed [phbm_pkg::ACC_W-1:0] r;
        s = sub ? ({a[phbm_pkg::ACC_W-1], a} - {b[phbm_pkg::ACC_W-1], b})
                : ({a[phbm_pkg::ACC_W-1], a} + {b[phbm_pkg::ACC_W-1], b});
        if (s[phbm_pkg::ACC_W] != s[phbm_pkg::ACC_W-1])
            r = s[phbm_pkg::ACC_W] ? MIN64 : MAX64;
        else
            r = s[phbm_pkg::ACC_W-1:0];
        return r;
    endfunction

    // Round half up to FRAC_BITS fraction bits, then clamp to 32 bits.
    function automatic logic signed [phbm_pkg::DATA_W-1:0] round_sat(
        input logic signed [phbm_pkg::ACC_W-1:0] acc
    );
        logic signed [phbm_pkg::ACC_W-1:0] sh;
        logic signed [phbm_pkg::ACC_W-1:0] q;
        logic signed [phbm_pkg::DATA_W-1:0] r;
        sh = acc >>> phbm_pkg::FRAC_BITS;
        q  = sh + $signed({{(phbm_pkg::ACC_W-1){1'b0}}, acc[phbm_pkg::FRAC_BITS-1]});
        if (q > MAX32)
            r = MAX32[phbm_pkg::DATA_W-1:0];
        else if (q < MIN32)
            r = MIN32[phbm_pkg::DATA_W-1:0];
        else
            r = q[phbm_pkg::DATA_W-1:0];
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (load.diag_we)
            diag_mem[load.short_addr] <= load.re;
        if (load.lower_we)
            lower_mem[load.lower_addr] <= {load.im, load.re};
        if (load.vec_we)
            vec_mem[load.short_addr] <= {load.im, load.re};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_diag)
            d_rd_reg <= diag_mem[ctrl.diag_addr];
        if (ctrl.rd_off)
            {m1_rd_reg, m0_rd_reg} <= lower_mem[ctrl.lower_addr];
        if (ctrl.rd_diag || ctrl.rd_off)
            {x1_rd_reg, x0_rd_reg} <= vec_mem[ctrl.vec_addr];
    end

    always_comb
    begin
        case (ctrl.mul_sel)
            phbm_pkg::MUL_XRE_D:
            begin
                op_a = x0_rd_reg;
                op_b = d_rd_reg;
            end
            phbm_pkg::MUL_XIM_D:
            begin
                op_a = x1_rd_reg;
                op_b = d_rd_reg;
            end
            phbm_pkg::MUL_M0X0:
            begin
                op_a = m0_rd_reg;
                op_b = x0_rd_reg;
            end
            phbm_pkg::MUL_M1X1:
            begin
                op_a = m1_rd_reg;
                op_b = x1_rd_reg;
            end
            phbm_pkg::MUL_M0X1:
            begin
                op_a = m0_rd_reg;
                op_b = x1_rd_reg;
            end
            phbm_pkg::MUL_M1X0:
            begin
                op_a = m1_rd_reg;
                op_b = x0_rd_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        product_next = op_a * op_b;
    end

    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        case (ctrl.acc_op)
            phbm_pkg::ACC_LOAD_RE:      acc_re_next = product_reg;
            phbm_pkg::ACC_LOAD_IM:      acc_im_next = product_reg;
            phbm_pkg::ACC_ADD_RE:       acc_re_next = sat_add(acc_re_reg, product_reg, 1'b0);
            phbm_pkg::ACC_ADD_IM:       acc_im_next = sat_add(acc_im_reg, product_reg, 1'b0);
            phbm_pkg::ACC_LOWER_SUB_RE:
                acc_re_next = sat_add(acc_re_reg, product_reg, !ctrl.upper);
            phbm_pkg::ACC_UPPER_SUB_IM:
                acc_im_next = sat_add(acc_im_reg, product_reg, ctrl.upper);
            default:
            begin
                acc_re_next = acc_re_reg;
                acc_im_next = acc_im_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
        acc_re_reg  <= acc_re_next;
        acc_im_reg  <= acc_im_next;
    end

    assign res_re = round_sat(acc_re_reg);
    assign res_im = round_sat(acc_im_reg);

endmodule

// File: design/packed_hermitian_block_matvec_unit.sv
// Channel | Handshake           | Beat contents
// --------+---------------------+------------------------------------------
// input   | in_valid / in_ready | kind, index, value_re, value_im, last
// output  | out_valid/out_ready | row, out_re, out_im, final_res
//
// A load beat (diagonal, off-diagonal or vector element) is written in the cycle it is
// accepted. A vector beat with last set starts a run that works through the rows one by one,
// paced by the one shared 32x32 multiplier and held up by output stalls.
// in_ready is low for the whole run; a result waiting in the output register holds the
// run at its output step. Reset clears only the sequencer and the output valid flag, and
// the stores hold whatever was last written.

module packed_hermitian_block_matvec_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [phbm_pkg::KIND_W-1:0]           kind,
    input  logic [phbm_pkg::IDX_W-1:0]            index,
    input  logic signed [phbm_pkg::DATA_W-1:0]    value_re,
    input  logic signed [phbm_pkg::DATA_W-1:0]    value_im,
    input  logic                                  last,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [phbm_pkg::ROW_W-1:0]            row,
    output logic signed [phbm_pkg::DATA_W-1:0]    out_re,
    output logic signed [phbm_pkg::DATA_W-1:0]    out_im,
    output logic                                  final_res
);

    `include "packed_hermitian_block_matvec_unit_assert.svh"

    logic                               in_accept;
    logic                               start;
    logic                               out_busy;
    logic                               emit;
    logic                               seq_idle;
    logic [phbm_pkg::J_W-1:0]           row_idx;
    logic                               last_row;
    phbm_pkg::load_t                    load;
    phbm_pkg::ctrl_t                    ctrl;
    logic signed [phbm_pkg::DATA_W-1:0] res_re;
    logic signed [phbm_pkg::DATA_W-1:0] res_im;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [phbm_pkg::ROW_W-1:0]         row_reg;
    logic signed [phbm_pkg::DATA_W-1:0] out_re_reg;
    logic signed [phbm_pkg::DATA_W-1:0] out_im_reg;
    logic                               final_reg;

    // Beats are taken only while the sequencer sits in its idle step.
    assign in_ready  = seq_idle;
    assign in_accept = in_valid && in_ready;

    // A vector beat with last starts the run even when its index is out of range.
    assign start = in_accept && (kind == phbm_pkg::KIND_VEC) && last;

    // Writes with an out-of-range index, and beats of the unused kind, are dropped.
    always_comb
    begin
        load.diag_we    = in_accept && (kind == phbm_pkg::KIND_DIAG)
                          && ($unsigned(index) < phbm_pkg::BLOCK_DIM);
        load.lower_we   = in_accept && (kind == phbm_pkg::KIND_OFF)
                          && ($unsigned(index) < phbm_pkg::LOWER_COUNT);
        load.vec_we     = in_accept && (kind == phbm_pkg::KIND_VEC)
                          && ($unsigned(index) < phbm_pkg::BLOCK_DIM);
        load.short_addr = phbm_pkg::J_W'(index);
        load.lower_addr = phbm_pkg::L_AW'(index);
        load.re         = value_re;
        load.im         = value_im;
    end

    phbm_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_busy (out_busy),
        .ctrl     (ctrl),
        .emit     (emit),
        .idle     (seq_idle),
        .row_idx  (row_idx),
        .last_row (last_row)
    );

    phbm_datapath u_dp (
        .clk    (clk),
        .load   (load),
        .ctrl   (ctrl),
        .res_re (res_re),
        .res_im (res_im)
    );

    // Output register: the sequencer writes it only when it is empty or draining.
    assign out_busy = out_valid_reg && !out_ready;

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            row_reg    <= phbm_pkg::ROW_W'(row_idx);
            out_re_reg <= res_re;
            out_im_reg <= res_im;
            final_reg  <= last_row;
        end
    end

    assign out_valid = out_valid_reg;
    assign row       = row_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;
    assign final_res = final_reg;

    // A start beat must take the block out of its idle step at once.
    `PHBM_ASSERT_NEXT(a_start_leaves_idle, start, !in_ready, "run did not start")

    // A result must never overwrite one that is still waiting.
    `PHBM_ASSERT_SAME(a_emit_free, emit, !(out_valid_reg && !out_ready), "result overwritten")

    // The result flagged final must belong to the last row.
    `PHBM_ASSERT_SAME(a_final_row, out_valid && final_res,
        row == phbm_pkg::ROW_W'(phbm_pkg::BLOCK_DIM - 1), "final flag on wrong row")

endmodule
